FILE: rtl/b64e_pkg.sv
package b64e_pkg;

  // One input item: a message byte and its end-of-message mark
  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } byte_item_t;

  // One result item: a single encoded character
  typedef struct packed {
    logic [6:0] out_char;
    logic       group_end;
    logic       message_end;
  } char_item_t;

  // One closed group handed from the front to the back.
  // Bytes that the group lacks are zero; n_bytes is 1, 2 or 3.
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] n_bytes;
    logic       msg_end;
  } group_t;

  localparam logic [6:0] PadChar   = 7'd61;
  localparam logic [6:0] UpperBase = 7'd65;
  localparam logic [6:0] LowerBase = 7'd71;  // 'a' less 26
  localparam logic [6:0] DigitBase = 7'd124; // '0' less 52, modulo 128
  localparam logic [6:0] PlusChar  = 7'd43;
  localparam logic [6:0] SlashChar = 7'd47;

  // Map a sextet onto the standard alphabet
  function automatic logic [6:0] sextet_char(input logic [5:0] v);
    logic [6:0] v7;
    v7 = {1'b0, v};
    if (v < 6'd26) begin
      return UpperBase + v7;
    end else if (v < 6'd52) begin
      return LowerBase + v7;
    end else if (v < 6'd62) begin
      return DigitBase + v7;
    end else if (v == 6'd62) begin
      return PlusChar;
    end else begin
      return SlashChar;
    end
  endfunction

endpackage

FILE: rtl/base64_stream_encoder.sv
// Channel  Direction  Payload                       Handshake
// byte     in         data_byte, final_byte         byte_valid / byte_stall
// char     out        out_char, group_end, msg end  char_valid / char_stall
//
// Bytes are taken one per cycle while the group queue has room; characters
// leave one per cycle from the output register while the consumer does not
// stall, so the sustained rate is four characters per three bytes.
// A closed group is written into the queue before the output register loads it.
// Reset clears the phase, the queue and the output valid.
// Either side may stall on its own; the queue takes up the difference.
module base64_stream_encoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  output logic                 byte_stall,
  input  b64e_pkg::byte_item_t byte_item,
  output logic                 char_valid,
  input  logic                 char_stall,
  output b64e_pkg::char_item_t char_item
);

  logic             push;
  logic             pop;
  logic             q_full;
  logic             q_valid;
  b64e_pkg::group_t push_group;
  b64e_pkg::group_t head;

  b64e_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_item  (byte_item),
    .q_full     (q_full),
    .byte_stall (byte_stall),
    .push       (push),
    .push_group (push_group)
  );

  b64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_group (push_group),
    .pop        (pop),
    .full       (q_full),
    .not_empty  (q_valid),
    .head       (head)
  );

  b64e_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .head       (head),
    .char_stall (char_stall),
    .pop        (pop),
    .char_valid (char_valid),
    .char_item  (char_item)
  );

endmodule

FILE: rtl/b64e_front.sv
module b64e_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  input  b64e_pkg::byte_item_t byte_item,
  input  logic                q_full,
  output logic                byte_stall,
  output logic                push,
  output b64e_pkg::group_t    push_group
);

  logic [1:0] phase;
  logic [1:0] phase_next;
  logic [7:0] first_held;
  logic [7:0] second_held;
  logic [1:0] eff_phase;
  logic       accept;
  logic       closes;

  // Hold off the producer while the queue has no room
  assign byte_stall = q_full;
  assign accept     = byte_valid && !q_full;

  // An unused phase code behaves as an empty group
  assign eff_phase = (phase == 2'd3) ? 2'd0 : phase;
  assign closes    = byte_item.final_byte || (eff_phase == 2'd2);
  assign push      = accept && closes;

  // Build the closed group, zero-filling absent bytes
  always_comb begin
    push_group.msg_end = byte_item.final_byte;
    push_group.b0      = first_held;
    push_group.b1      = second_held;
    push_group.b2      = 8'd0;
    push_group.n_bytes = 2'd3;
    phase_next         = 2'd0;
    case (eff_phase)
      2'd0: begin
        push_group.b0      = byte_item.data_byte;
        push_group.b1      = 8'd0;
        push_group.n_bytes = 2'd1;
        phase_next         = byte_item.final_byte ? 2'd0 : 2'd1;
      end
      2'd1: begin
        push_group.b1      = byte_item.data_byte;
        push_group.n_bytes = 2'd2;
        phase_next         = byte_item.final_byte ? 2'd0 : 2'd2;
      end
      default: begin
        push_group.b2 = byte_item.data_byte;
      end
    endcase
  end

  // Advance the phase and store pending bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= 2'd0;
      first_held  <= 8'd0;
      second_held <= 8'd0;
    end else if (accept) begin
      phase <= phase_next;
      if (eff_phase == 2'd0) begin
        first_held <= byte_item.data_byte;
      end
      if (eff_phase == 2'd1) begin
        second_held <= byte_item.data_byte;
      end
    end
  end

endmodule

FILE: rtl/b64e_queue.sv
module b64e_queue #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  b64e_pkg::group_t push_group,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output b64e_pkg::group_t head
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  b64e_pkg::group_t slots [DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;

  assign full      = (count == FullCnt);
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  // Write the incoming group
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_group;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/b64e_back.sv
module b64e_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  b64e_pkg::group_t     head,
  input  logic                 char_stall,
  output logic                 pop,
  output logic                 char_valid,
  output b64e_pkg::char_item_t char_item
);

  logic [1:0] idx;
  logic       advance;
  logic       load;
  logic [5:0] sextet;
  logic       pad;
  b64e_pkg::char_item_t next_item;

  // The output register moves when it is empty or being taken
  assign advance = !char_valid || !char_stall;
  assign load    = advance && q_valid;
  assign pop     = load && (idx == 2'd3);

  // Pick the sextet of the current character
  always_comb begin
    case (idx)
      2'd0:    sextet = head.b0[7:2];
      2'd1:    sextet = {head.b0[1:0], head.b1[7:4]};
      2'd2:    sextet = {head.b1[3:0], head.b2[7:6]};
      default: sextet = head.b2[5:0];
    endcase
  end

  // Characters past the group's byte count are padding
  assign pad = (idx > head.n_bytes);

  always_comb begin
    next_item.out_char    = pad ? b64e_pkg::PadChar : b64e_pkg::sextet_char(sextet);
    next_item.group_end   = (idx == 2'd3);
    next_item.message_end = (idx == 2'd3) && head.msg_end;
  end

  // Load the output register and step through the group
  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
      idx        <= 2'd0;
    end else if (advance) begin
      char_valid <= q_valid;
      if (q_valid) begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_item <= next_item;
    end
  end

endmodule

FILE: rtl/b64e_checker.sv
module b64e_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 byte_valid,
  input logic                 byte_stall,
  input b64e_pkg::byte_item_t byte_item,
  input logic                 char_valid,
  input logic                 char_stall,
  input b64e_pkg::char_item_t char_item
);

  // A stalled character stays offered and unchanged
  a_hold: assert property (@(posedge clk) disable iff (rst)
    char_valid && char_stall |=> char_valid && $stable(char_item))
    else $error("stalled character changed");

  // Nothing is offered straight after reset
  a_reset: assert property (@(posedge clk) rst |=> !char_valid)
    else $error("character valid after reset");

  // The message ends only on a group boundary
  a_msg_end: assert property (@(posedge clk) disable iff (rst)
    char_valid && char_item.message_end |-> char_item.group_end)
    else $error("message end off a group boundary");

  // Every character is from the alphabet or is padding
  a_alphabet: assert property (@(posedge clk) disable iff (rst)
    char_valid |->
      (char_item.out_char >= 7'd65 && char_item.out_char <= 7'd90) ||
      (char_item.out_char >= 7'd97 && char_item.out_char <= 7'd122) ||
      (char_item.out_char >= 7'd48 && char_item.out_char <= 7'd57) ||
      char_item.out_char == 7'd43 || char_item.out_char == 7'd47 ||
      char_item.out_char == 7'd61)
    else $error("character outside the alphabet");

endmodule

bind base64_stream_encoder b64e_checker u_chk (.*);
